>>> hdl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// Used by fbpa_stack, fbpa_resp and the top level; depends on nothing.

package fbpa_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 256;
  localparam int unsigned ADDR_W_DEF     = 32;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned FREED_W    = 32;
  localparam int unsigned BASE_W     = 32;
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned POOL_CNT_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL = 2'd2;

  localparam logic [BASE_W-1:0]     BASE_RST = 32'd0;
  localparam logic [ELEM_W-1:0]     ELEM_RST = 16'd1;
  localparam logic [POOL_CNT_W-1:0] POOL_RST = 9'd256;

  // Stage one result of an operation, handed to the response stage
  typedef struct packed {
    logic            grant;
    logic            marked;
    logic [ST_W-1:0] status;
  } stage_t;

endpackage

>>> hdl/fbpa_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.

module fbpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/fbpa_stack.sv
// Free address stack: allocation count, written marks, address RAM and stage one.
// Depends on fbpa_pkg and fbpa_ram.

module fbpa_stack #(
  parameter int unsigned POOL_DEPTH    = fbpa_pkg::POOL_DEPTH_DEF,
  parameter int unsigned ADDRESS_WIDTH = fbpa_pkg::ADDR_W_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [fbpa_pkg::OP_W-1:0]       op_i,
  input  logic [fbpa_pkg::FREED_W-1:0]    freed_i,
  input  logic [fbpa_pkg::ELEM_W-1:0]     elem_size_i,
  input  logic [fbpa_pkg::POOL_CNT_W-1:0] pool_count_i,
  input  logic                            advance_i,
  output logic                            s1_valid_o,
  output fbpa_pkg::stage_t                s1_o,
  output logic [ADDRESS_WIDTH-1:0]        s1_product_o,
  output logic [ADDRESS_WIDTH-1:0]        s1_rdata_o
);

  localparam int unsigned IDX_W  = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > fbpa_pkg::POOL_CNT_W) ? CNT_W : fbpa_pkg::POOL_CNT_W;
  localparam int unsigned PROD_W = IDX_W + fbpa_pkg::ELEM_W;

  logic [CNT_W-1:0]         count_q, count_d, count_m1;
  logic [POOL_DEPTH-1:0]    marks_q, marks_d;
  logic [CMP_W-1:0]         pool_ext, depth_c, limit;
  logic                     exhausted, empty;
  logic [IDX_W-1:0]         idx_alloc, idx_free;
  logic [PROD_W-1:0]        prod_full;
  logic                     ram_we, ram_re;
  logic                     s1_valid_q;
  fbpa_pkg::stage_t         s1_q, s1_d;
  logic [ADDRESS_WIDTH-1:0] product_q;

  assign pool_ext  = CMP_W'(pool_count_i);
  assign depth_c   = CMP_W'(POOL_DEPTH);
  assign limit     = (pool_ext < depth_c) ? pool_ext : depth_c;
  assign exhausted = CMP_W'(count_q) >= limit;
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - CNT_W'(1);
  assign idx_alloc = count_q[IDX_W-1:0];
  assign idx_free  = count_m1[IDX_W-1:0];
  assign prod_full = PROD_W'(idx_alloc) * PROD_W'(elem_size_i);

  always_comb begin
    count_d = count_q;
    marks_d = marks_q;
    s1_d    = '{grant: 1'b0, marked: marks_q[idx_alloc], status: fbpa_pkg::ST_OK};
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    case (op_i)
      fbpa_pkg::OP_ALLOC: begin
        if (exhausted) begin
          s1_d.status = fbpa_pkg::ST_EXHAUSTED;
        end else begin
          s1_d.grant = 1'b1;
          ram_re     = accept_i;
          count_d    = count_q + CNT_W'(1);
        end
      end
      fbpa_pkg::OP_FREE: begin
        if (empty) begin
          s1_d.status = fbpa_pkg::ST_EMPTY_FREE;
        end else begin
          ram_we            = accept_i;
          marks_d[idx_free] = 1'b1;
          count_d           = count_m1;
        end
      end
      fbpa_pkg::OP_CLEAR: begin
        marks_d = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  fbpa_ram #(
    .WIDTH (ADDRESS_WIDTH),
    .DEPTH (POOL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_free),
    .wdata_i (ADDRESS_WIDTH'(freed_i)),
    .re_i    (ram_re),
    .raddr_i (idx_alloc),
    .rdata_o (s1_rdata_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      marks_q    <= '0;
      s1_valid_q <= 1'b0;
    end else if (accept_i) begin
      count_q    <= count_d;
      marks_q    <= marks_d;
      s1_valid_q <= 1'b1;
    end else if (advance_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q      <= s1_d;
      product_q <= ADDRESS_WIDTH'(prod_full);
    end
  end

  assign s1_valid_o   = s1_valid_q;
  assign s1_o         = s1_q;
  assign s1_product_o = product_q;

endmodule

>>> hdl/fbpa_resp.sv
// Response stage: picks the granted address and holds the result for the receiver.
// Depends on fbpa_pkg.

module fbpa_resp #(
  parameter int unsigned ADDRESS_WIDTH = fbpa_pkg::ADDR_W_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s1_valid_i,
  input  fbpa_pkg::stage_t            s1_i,
  input  logic [ADDRESS_WIDTH-1:0]    s1_product_i,
  input  logic [ADDRESS_WIDTH-1:0]    s1_rdata_i,
  input  logic [fbpa_pkg::BASE_W-1:0] base_i,
  output logic                        advance_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ADDRESS_WIDTH-1:0]    out_addr_o,
  output logic [fbpa_pkg::ST_W-1:0]   out_status_o
);

  logic                      out_valid_q;
  logic [ADDRESS_WIDTH-1:0]  out_addr_q, out_addr_d;
  logic [fbpa_pkg::ST_W-1:0] out_status_q;
  logic                      load;

  assign advance_o = !out_valid_q || out_ready_i;
  assign load      = s1_valid_i && advance_o;

  always_comb begin
    out_addr_d = '0;
    if (s1_i.grant) begin
      out_addr_d = s1_i.marked ? s1_rdata_i : ADDRESS_WIDTH'(base_i) + s1_product_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_addr_q   <= out_addr_d;
      out_status_q <= s1_i.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_status_q;

endmodule

>>> hdl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: configuration registers and stream ports.
// Depends on fbpa_pkg, fbpa_stack and fbpa_resp.
//
// Usage:
//   Operations enter on the s_axis channel: tuser carries the operation (allocate,
//   free, clear), tdata the address handed back on a free. Each operation yields
//   one result on m_axis: tdata the granted address (zero unless an allocate
//   succeeds), tuser the status (ok, pool exhausted, free with nothing allocated).
//   The cfg channel writes base address, block size and pool count; it is always
//   ready. The user must write it only while no operation is in flight; the block
//   does not enforce this. An input transfer is registered into stage one, then into
//   the output register. One operation is taken every cycle unless the receiver
//   stalls; the stack count and written marks update at the input transfer, and
//   the address RAM read is registered into stage one. Reset empties the pool (count
//   zero, all entries at their initial addresses) and restores the register defaults.
//   When the receiver stalls, the result is held in the output register and one more
//   operation parks in stage one; then s_axis_tready drops until the result is taken.

module fixed_block_pool_allocator_top #(
  parameter int unsigned POOL_DEPTH    = fbpa_pkg::POOL_DEPTH_DEF,
  parameter int unsigned ADDRESS_WIDTH = fbpa_pkg::ADDR_W_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fbpa_pkg::FREED_W-1:0]         s_axis_tdata,  // [31:0] freed_address
  input  logic [fbpa_pkg::OP_W-1:0]            s_axis_tuser,  // [1:0] op
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((ADDRESS_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // block_address from bit 0
  output logic [fbpa_pkg::ST_W-1:0]            m_axis_tuser,  // [1:0] status
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned TDATA_W = ((ADDRESS_WIDTH + 7) / 8) * 8;

  logic [fbpa_pkg::BASE_W-1:0]     base_q;
  logic [fbpa_pkg::ELEM_W-1:0]     elem_q;
  logic [fbpa_pkg::POOL_CNT_W-1:0] pool_q;
  logic                            accept, advance, s1_valid;
  fbpa_pkg::stage_t                s1;
  logic [ADDRESS_WIDTH-1:0]        s1_product, s1_rdata, out_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= fbpa_pkg::BASE_RST;
      elem_q <= fbpa_pkg::ELEM_RST;
      pool_q <= fbpa_pkg::POOL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fbpa_pkg::REG_BASE: base_q <= cfg_data_i[fbpa_pkg::BASE_W-1:0];
        fbpa_pkg::REG_ELEM: elem_q <= cfg_data_i[fbpa_pkg::ELEM_W-1:0];
        fbpa_pkg::REG_POOL: pool_q <= cfg_data_i[fbpa_pkg::POOL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  fbpa_stack #(
    .POOL_DEPTH    (POOL_DEPTH),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (s_axis_tuser),
    .freed_i      (s_axis_tdata),
    .elem_size_i  (elem_q),
    .pool_count_i (pool_q),
    .advance_i    (advance),
    .s1_valid_o   (s1_valid),
    .s1_o         (s1),
    .s1_product_o (s1_product),
    .s1_rdata_o   (s1_rdata)
  );

  fbpa_resp #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_resp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .s1_i         (s1),
    .s1_product_i (s1_product),
    .s1_rdata_i   (s1_rdata),
    .base_i       (base_q),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = TDATA_W'(out_addr);

endmodule
